>>> rtl/cau_pkg.sv
`timescale 1ns / 1ps

package cau_pkg;

  localparam int FRAC_BITS = 16;

  // Width of the division remainder: magnitude (64) shifted up by up to 32 quotient bits
  localparam int REM_W = 96;
  localparam int Q_W   = 32;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_MAG = 3'd4,
    MODE_EQ  = 3'd5
  } mode_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  // Pipeline payload of the iterative divide / square-root stages
  typedef struct packed {
    logic [2:0]       mode;
    logic             is_equal;
    logic [31:0]      dir_re;
    logic [31:0]      dir_im;
    logic             dir_sat;
    logic             dz;
    logic             re_neg;
    logic             im_neg;
    logic             re_ovf;
    logic             im_ovf;
    logic [63:0]      den;
    logic [REM_W-1:0] re_rem;
    logic [REM_W-1:0] im_rem;
    logic [Q_W-1:0]   re_q;
    logic [Q_W-1:0]   im_q;
    logic [63:0]      sq_rem;
    logic [31:0]      sq_r;
  } it_t;

  // Clamp a sign and magnitude to the signed 32-bit range
  function automatic sat_t clamp_sm(input logic neg, input logic [63:0] mag);
    sat_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.sat = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = 32'(64'd0 - mag);
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        r.sat = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.val = mag[31:0];
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; the pipeline stalls as a whole only while the
// output register holds an item that the sink has not taken.
// Reset: rst_n (synchronous, active low) clears every stage valid bit; the
// datapath registers carry no reset.

module complex_arithmetic_unit (
  input  logic         clk,
  input  logic         rst_n,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // lhs_re[31:0], lhs_im[63:32], rhs_re[95:64], rhs_im[127:96]
  input  logic [2:0]   in_tuser,   // mode[2:0]
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // res_re[31:0], res_im[63:32]
  output logic [2:0]   out_tuser   // is_equal[0], status[2:1]
);

  localparam int F  = cau_pkg::FRAC_BITS;
  localparam int NB = cau_pkg::Q_W;
  localparam int RW = cau_pkg::REM_W;

  // Global advance: the whole pipeline moves unless the output item is held
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------------------------------------------------------- stage 1
  // Register the operands.
  logic               s1_v_r;
  logic [2:0]         s1_mode_r;
  logic signed [31:0] s1_a_r, s1_b_r, s1_c_r, s1_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r <= in_tuser;
      s1_a_r    <= in_tdata[31:0];
      s1_b_r    <= in_tdata[63:32];
      s1_c_r    <= in_tdata[95:64];
      s1_d_r    <= in_tdata[127:96];
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Six products, the equality flag and the finished add / subtract.
  logic               s2_v_r;
  logic [2:0]         s2_mode_r;
  logic               s2_eq_r;
  cau_pkg::sat_t      s2_re_r, s2_im_r;
  logic signed [63:0] s2_p0_r, s2_p1_r, s2_p2_r, s2_p3_r, s2_p4_r, s2_p5_r;

  logic signed [31:0] m4_x, m5_x;
  logic [32:0]        as_re, as_im;
  cau_pkg::sat_t      as_re_c, as_im_c;
  logic               is_sub;

  always_comb begin
    is_sub = (s1_mode_r == cau_pkg::MODE_SUB);
    m4_x   = (s1_mode_r == cau_pkg::MODE_MAG) ? s1_a_r : s1_c_r;
    m5_x   = (s1_mode_r == cau_pkg::MODE_MAG) ? s1_b_r : s1_d_r;
    as_re  = is_sub ? ({s1_a_r[31], s1_a_r} - {s1_c_r[31], s1_c_r})
                    : ({s1_a_r[31], s1_a_r} + {s1_c_r[31], s1_c_r});
    as_im  = is_sub ? ({s1_b_r[31], s1_b_r} - {s1_d_r[31], s1_d_r})
                    : ({s1_b_r[31], s1_b_r} + {s1_d_r[31], s1_d_r});
    as_re_c = cau_pkg::clamp_sm(as_re[32],
                {31'd0, as_re[32] ? (~as_re + 33'd1) : as_re});
    as_im_c = cau_pkg::clamp_sm(as_im[32],
                {31'd0, as_im[32] ? (~as_im + 33'd1) : as_im});
    if (!(s1_mode_r == cau_pkg::MODE_ADD || is_sub)) begin
      as_re_c = '0;
      as_im_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mode_r <= s1_mode_r;
      s2_eq_r   <= (s1_a_r == s1_c_r) && (s1_b_r == s1_d_r);
      s2_re_r   <= as_re_c;
      s2_im_r   <= as_im_c;
      s2_p0_r   <= s1_a_r * s1_c_r;
      s2_p1_r   <= s1_b_r * s1_d_r;
      s2_p2_r   <= s1_a_r * s1_d_r;
      s2_p3_r   <= s1_b_r * s1_c_r;
      s2_p4_r   <= m4_x * m4_x;
      s2_p5_r   <= m5_x * m5_x;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Sums of products and the denominator (or the squared magnitude).
  logic               s3_v_r;
  logic [2:0]         s3_mode_r;
  logic               s3_eq_r;
  cau_pkg::sat_t      s3_re_r, s3_im_r;
  logic [64:0]        s3_rsum_r, s3_isum_r;
  logic [63:0]        s3_den_r;

  logic [64:0] e0, e1, e2, e3;
  logic        is_mul;

  always_comb begin
    is_mul = (s2_mode_r == cau_pkg::MODE_MUL);
    e0 = {s2_p0_r[63], s2_p0_r};
    e1 = {s2_p1_r[63], s2_p1_r};
    e2 = {s2_p2_r[63], s2_p2_r};
    e3 = {s2_p3_r[63], s2_p3_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_mode_r <= s2_mode_r;
      s3_eq_r   <= s2_eq_r;
      s3_re_r   <= s2_re_r;
      s3_im_r   <= s2_im_r;
      s3_rsum_r <= is_mul ? (e0 - e1) : (e0 + e1);
      s3_isum_r <= is_mul ? (e2 + e3) : (e3 - e2);
      s3_den_r  <= s2_p4_r[63:0] + s2_p5_r[63:0];
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Sign and magnitude; finish multiply.
  logic               s4_v_r;
  logic [2:0]         s4_mode_r;
  logic               s4_eq_r;
  cau_pkg::sat_t      s4_re_r, s4_im_r;
  logic               s4_rneg_r, s4_ineg_r;
  logic [63:0]        s4_rmag_r, s4_imag_r;
  logic [63:0]        s4_den_r;

  logic [63:0]   rmag, imag;
  cau_pkg::sat_t mul_re, mul_im, dir_re, dir_im;

  always_comb begin
    rmag   = s3_rsum_r[64] ? 64'(~s3_rsum_r + 65'd1) : s3_rsum_r[63:0];
    imag   = s3_isum_r[64] ? 64'(~s3_isum_r + 65'd1) : s3_isum_r[63:0];
    mul_re = cau_pkg::clamp_sm(s3_rsum_r[64], rmag >> F);
    mul_im = cau_pkg::clamp_sm(s3_isum_r[64], imag >> F);
    dir_re = s3_re_r;
    dir_im = s3_im_r;
    if (s3_mode_r == cau_pkg::MODE_MUL) begin
      dir_re = mul_re;
      dir_im = mul_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_mode_r <= s3_mode_r;
      s4_eq_r   <= s3_eq_r;
      s4_re_r   <= dir_re;
      s4_im_r   <= dir_im;
      s4_rneg_r <= s3_rsum_r[64];
      s4_ineg_r <= s3_isum_r[64];
      s4_rmag_r <= rmag;
      s4_imag_r <= imag;
      s4_den_r  <= s3_den_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Check quotient overflow and seed the divide and square-root iterations.
  cau_pkg::it_t it_r   [0:NB];
  cau_pkg::it_t it_nxt [0:NB];
  logic         itv_r  [0:NB];

  logic [RW-1:0] den_top, rnum, inum;

  always_comb begin
    den_top = {s4_den_r, 32'd0};
    rnum    = {32'd0, s4_rmag_r} << F;
    inum    = {32'd0, s4_imag_r} << F;
    it_nxt[0].mode     = s4_mode_r;
    it_nxt[0].is_equal = s4_eq_r;
    it_nxt[0].dir_re   = s4_re_r.val;
    it_nxt[0].dir_im   = s4_im_r.val;
    it_nxt[0].dir_sat  = s4_re_r.sat | s4_im_r.sat;
    it_nxt[0].dz       = (s4_den_r == 64'd0);
    it_nxt[0].re_neg   = s4_rneg_r;
    it_nxt[0].im_neg   = s4_ineg_r;
    it_nxt[0].re_ovf   = (rnum >= den_top);
    it_nxt[0].im_ovf   = (inum >= den_top);
    it_nxt[0].den      = s4_den_r;
    it_nxt[0].re_rem   = rnum;
    it_nxt[0].im_rem   = inum;
    it_nxt[0].re_q     = '0;
    it_nxt[0].im_q     = '0;
    it_nxt[0].sq_rem   = s4_den_r;
    it_nxt[0].sq_r     = '0;
  end

  // ------------------------------------------------------ iterative stages
  // Each stage settles one quotient bit of both parts and one root bit.
  for (genvar k = 0; k < NB; k++) begin : g_it
    localparam int B = NB - 1 - k;

    logic [RW-1:0] dsh;
    logic [65:0]   trial;

    always_comb begin
      it_nxt[k+1] = it_r[k];
      dsh   = {32'd0, it_r[k].den} << B;
      trial = ({34'd0, it_r[k].sq_r} << (B + 1)) + (66'd1 << (2 * B));
      if (it_r[k].re_rem >= dsh) begin
        it_nxt[k+1].re_rem  = it_r[k].re_rem - dsh;
        it_nxt[k+1].re_q[B] = 1'b1;
      end
      if (it_r[k].im_rem >= dsh) begin
        it_nxt[k+1].im_rem  = it_r[k].im_rem - dsh;
        it_nxt[k+1].im_q[B] = 1'b1;
      end
      if ({2'd0, it_r[k].sq_rem} >= trial) begin
        it_nxt[k+1].sq_rem  = 64'({2'd0, it_r[k].sq_rem} - trial);
        it_nxt[k+1].sq_r[B] = 1'b1;
      end
    end
  end

  for (genvar k = 0; k <= NB; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        itv_r[k] <= 1'b0;
      end else if (adv) begin
        itv_r[k] <= (k == 0) ? s4_v_r : itv_r[(k == 0) ? 0 : k - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        it_r[k] <= it_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------- output stage
  // Select the result by mode, clamp quotient and root, form status.
  logic          out_v_r;
  logic [31:0]   out_re_r, out_im_r;
  logic          out_eq_r;
  logic [1:0]    out_st_r;

  cau_pkg::it_t  fin;
  cau_pkg::sat_t f_re, f_im;
  logic          f_div0;
  logic [1:0]    f_st;

  always_comb begin
    fin    = it_r[NB];
    f_re   = '0;
    f_im   = '0;
    f_div0 = 1'b0;
    case (fin.mode)
      cau_pkg::MODE_ADD, cau_pkg::MODE_SUB, cau_pkg::MODE_MUL: begin
        f_re.val = fin.dir_re;
        f_im.val = fin.dir_im;
        f_re.sat = fin.dir_sat;
      end
      cau_pkg::MODE_DIV: begin
        if (fin.dz) begin
          f_div0 = 1'b1;
        end else begin
          f_re = cau_pkg::clamp_sm(fin.re_neg, {31'd0, fin.re_ovf, fin.re_q});
          f_im = cau_pkg::clamp_sm(fin.im_neg, {31'd0, fin.im_ovf, fin.im_q});
        end
      end
      cau_pkg::MODE_MAG: begin
        f_re = cau_pkg::clamp_sm(1'b0, {32'd0, fin.sq_r});
      end
      default: begin
        f_re = '0;
      end
    endcase
    if (f_div0) begin
      f_st = cau_pkg::ST_DIV0;
    end else if (f_re.sat || f_im.sat) begin
      f_st = cau_pkg::ST_SAT;
    end else begin
      f_st = cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= itv_r[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_re_r <= f_re.val;
      out_im_r <= f_im.val;
      out_eq_r <= fin.is_equal;
      out_st_r <= f_st;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_im_r, out_re_r};
  assign out_tuser  = {out_st_r, out_eq_r};

endmodule
